// ----- hdl/qgdt_pkg.sv -----
package qgdt_pkg;

  // Width of the qubit fields of an input beat.
  localparam int QF_W = 6;
  // Width of the configuration data and of the per-core counts.
  localparam int CFG_W = 7;
  // Step counter width of the core-index divider.
  localparam int DIV_CNT_W = $clog2(QF_W + 1);

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_EDGE    = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_QUERY   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_DUP   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_QUBIT_COUNT     = 2'd0,
    CFG_QUBITS_PER_CORE = 2'd1,
    CFG_COMM_PER_CORE   = 2'd2,
    CFG_FULL_CONN       = 2'd3
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic sweep_init;
    logic sweep_step;
    logic edge_rd;
    logic edge_wr;
    logic div_init;
    logic div_step;
    logic full_init;
    logic full_step;
    logic fw_init;
    logic col_init;
    logic col_step;
    logic row_next;
    logic resp_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_t opcode;
    logic    out_of_range;
    logic    self_loop;
    logic    full_mode;
    logic    n_zero;
    logic    sweep_last;
    logic    div_done;
    logic    full_last;
    logic    a_inf;
    logic    j_last;
    logic    i_last;
    logic    k_last;
    logic    out_busy;
    logic    wb_busy;
  } stat_t;

endpackage

// ----- hdl/qgdt_ram.sv -----
module qgdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_a_addr,
  output logic [WIDTH-1:0] rd_a_data,
  input  logic [AW-1:0]    rd_b_addr,
  output logic [WIDTH-1:0] rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_a_data_r;
  logic [WIDTH-1:0] rd_b_data_r;

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data_r <= mem[rd_a_addr];
    rd_b_data_r <= mem[rd_b_addr];
  end

  assign rd_a_data = rd_a_data_r;
  assign rd_b_data = rd_b_data_r;

endmodule

// ----- hdl/qgdt_ctrl.sv -----
module qgdt_ctrl import qgdt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_CLEAR,
    S_EDGE_WAIT,
    S_EDGE_WR,
    S_QUERY,
    S_FULL,
    S_ROW_RD,
    S_ROW_CHK,
    S_COL,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  // Next state and datapath commands.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.opcode)
          OP_CLEAR: begin
            cmd.sweep_init = 1'b1;
            state_nxt      = S_CLEAR;
          end
          OP_EDGE: begin
            if (stat.out_of_range || stat.self_loop) begin
              state_nxt = S_RESP;
            end else begin
              cmd.edge_rd = 1'b1;
              state_nxt   = S_EDGE_WAIT;
            end
          end
          OP_QUERY: begin
            if (stat.out_of_range) begin
              state_nxt = S_RESP;
            end else begin
              cmd.edge_rd  = 1'b1;
              cmd.div_init = 1'b1;
              state_nxt    = S_QUERY;
            end
          end
          OP_COMPUTE: begin
            priority if (stat.n_zero) begin
              state_nxt = S_RESP;
            end else if (stat.full_mode) begin
              cmd.full_init = 1'b1;
              state_nxt     = S_FULL;
            end else begin
              cmd.fw_init = 1'b1;
              state_nxt   = S_ROW_RD;
            end
          end
        endcase
      end
      S_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_RESP;
        end
      end
      S_EDGE_WAIT: begin
        state_nxt = S_EDGE_WR;
      end
      S_EDGE_WR: begin
        cmd.edge_wr = 1'b1;
        state_nxt   = S_RESP;
      end
      S_QUERY: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_RESP;
        end
      end
      S_FULL: begin
        cmd.full_step = 1'b1;
        if (stat.full_last) begin
          cmd.fw_init = 1'b1;
          state_nxt   = S_ROW_RD;
        end
      end
      S_ROW_RD: begin
        state_nxt = S_ROW_CHK;
      end
      S_ROW_CHK: begin
        if (stat.a_inf) begin
          cmd.row_next = 1'b1;
          state_nxt    = (stat.i_last && stat.k_last) ? S_RESP : S_ROW_RD;
        end else begin
          cmd.col_init = 1'b1;
          state_nxt    = S_COL;
        end
      end
      S_COL: begin
        cmd.col_step = 1'b1;
        if (stat.j_last) begin
          cmd.row_next = 1'b1;
          state_nxt    = (stat.i_last && stat.k_last) ? S_RESP : S_ROW_RD;
        end
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.resp_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready_nxt = (state_nxt == S_IDLE);

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

// ----- hdl/qgdt_dp.sv -----
module qgdt_dp import qgdt_pkg::*; #(
  parameter int MAX_QUBITS = 64,
  parameter int DIST_WIDTH = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [1:0]            in_opcode,
  input  logic [QF_W-1:0]       in_src_qubit,
  input  logic [QF_W-1:0]       in_dst_qubit,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [DIST_WIDTH-1:0] out_hop_distance,
  output logic                  out_core_distance,
  output logic [DIST_WIDTH-1:0] out_min_hops,
  output logic                  out_reachable,
  input  cmd_t                  cmd,
  output stat_t                 stat
);

  localparam int QW    = $clog2(MAX_QUBITS);
  localparam int NW    = QW + 1;
  localparam int AW    = 2 * QW;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = NW + QF_W;
  localparam int DW    = DIST_WIDTH;
  localparam logic [DW-1:0] INF   = '1;
  localparam logic [QW-1:0] Q_TOP = QW'(MAX_QUBITS - 1);

  // Configuration registers.
  logic [CFG_W-1:0] qubit_count_r;
  logic [CFG_W-1:0] qpc_r;
  logic [CFG_W-1:0] cqpc_r;
  logic             full_conn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qubit_count_r <= CFG_W'(64);
      qpc_r         <= CFG_W'(64);
      cqpc_r        <= CFG_W'(64);
      full_conn_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_QUBIT_COUNT:     qubit_count_r <= cfg_data;
        CFG_QUBITS_PER_CORE: qpc_r         <= cfg_data;
        CFG_COMM_PER_CORE:   cqpc_r        <= cfg_data;
        CFG_FULL_CONN:       full_conn_r   <= cfg_data[0];
      endcase
    end
  end

  // Captured input beat.
  opcode_t         opcode_r;
  logic [QF_W-1:0] src_r;
  logic [QF_W-1:0] dst_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      opcode_r <= opcode_t'(in_opcode);
      src_r    <= in_src_qubit;
      dst_r    <= in_dst_qubit;
    end
  end

  // Active qubit count and range check.
  logic [NW-1:0] n_act;
  logic [QW-1:0] n_m1;
  logic          oor;
  logic [QW-1:0] s_q;
  logic [QW-1:0] d_q;

  always_comb begin
    if (int'(qubit_count_r) >= MAX_QUBITS) begin
      n_act = NW'(MAX_QUBITS);
    end else begin
      n_act = NW'(qubit_count_r);
    end
  end

  assign n_m1 = QW'(n_act - NW'(1));
  assign oor  = (CW'(src_r) >= CW'(n_act)) || (CW'(dst_r) >= CW'(n_act));
  assign s_q  = QW'(src_r);
  assign d_q  = QW'(dst_r);

  // Row, column and pivot counters.
  logic [QW-1:0] i_r, j_r, k_r;
  logic          j_last, i_last, k_last, sweep_row_end;

  assign j_last        = (j_r == n_m1);
  assign i_last        = (i_r == n_m1);
  assign k_last        = (k_r == n_m1);
  assign sweep_row_end = (j_r == Q_TOP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
    end else begin
      priority if (cmd.sweep_init || cmd.full_init || cmd.fw_init) begin
        i_r <= '0;
      end else if (cmd.sweep_step && sweep_row_end) begin
        i_r <= i_r + 1'b1;
      end else if (cmd.full_step && j_last) begin
        i_r <= i_r + 1'b1;
      end else if (cmd.row_next) begin
        i_r <= i_last ? '0 : i_r + 1'b1;
      end

      priority if (cmd.sweep_init || cmd.full_init || cmd.col_init) begin
        j_r <= '0;
      end else if (cmd.sweep_step) begin
        j_r <= sweep_row_end ? '0 : j_r + 1'b1;
      end else if (cmd.full_step) begin
        j_r <= j_last ? '0 : j_r + 1'b1;
      end else if (cmd.col_step) begin
        j_r <= j_r + 1'b1;
      end

      priority if (cmd.fw_init) begin
        k_r <= '0;
      end else if (cmd.row_next && i_last) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  // Core and local-index tracking for the full-connectivity pass.
  logic [QW-1:0]    ci_core_r, cj_core_r;
  logic [CFG_W-1:0] ci_loc_r, cj_loc_r;
  logic             ci_wrap, cj_wrap;
  logic             comm_i, comm_j, full_allow;

  assign ci_wrap = (CFG_W'(ci_loc_r + 1'b1) == qpc_r);
  assign cj_wrap = (CFG_W'(cj_loc_r + 1'b1) == qpc_r);

  always_ff @(posedge clk) begin
    if (cmd.full_init) begin
      ci_core_r <= '0;
      ci_loc_r  <= '0;
    end else if (cmd.full_step && j_last && (qpc_r != '0)) begin
      ci_core_r <= ci_wrap ? ci_core_r + 1'b1 : ci_core_r;
      ci_loc_r  <= ci_wrap ? '0 : ci_loc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.full_init || (cmd.full_step && j_last)) begin
      cj_core_r <= '0;
      cj_loc_r  <= '0;
    end else if (cmd.full_step && (qpc_r != '0)) begin
      cj_core_r <= cj_wrap ? cj_core_r + 1'b1 : cj_core_r;
      cj_loc_r  <= cj_wrap ? '0 : cj_loc_r + 1'b1;
    end
  end

  assign comm_i     = (qpc_r == '0) || (ci_loc_r < cqpc_r);
  assign comm_j     = (qpc_r == '0) || (cj_loc_r < cqpc_r);
  assign full_allow = (i_r != j_r) && ((ci_core_r == cj_core_r) || (comm_i && comm_j));

  // Table memory.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic [AW-1:0] rd_a_addr, rd_b_addr;
  logic [DW-1:0] rd_a_data, rd_b_data;

  qgdt_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  // Point read capture for edge and query beats.
  logic          rd_pend_r;
  logic [DW-1:0] cap_r;
  logic          dup_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.edge_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      cap_r <= rd_a_data;
    end
    if (cmd.load_item) begin
      dup_r <= 1'b0;
    end else if (cmd.edge_wr) begin
      dup_r <= (cap_r == DW'(1));
    end
  end

  // Relaxation pipeline: reads issued in one cycle, write-back in the next.
  logic          wb_busy_r;
  logic [QW-1:0] wb_i_r, wb_j_r;
  logic [DW-1:0] a_r;
  logic [DW:0]   relax_sum;
  logic [DW-1:0] relax_sat;
  logic          wb_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_busy_r <= 1'b0;
    end else begin
      wb_busy_r <= cmd.col_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.col_step) begin
      wb_i_r <= i_r;
      wb_j_r <= j_r;
    end
    if (cmd.col_init) begin
      a_r <= rd_a_data;
    end
  end

  assign relax_sum = {1'b0, a_r} + {1'b0, rd_b_data};
  assign relax_sat = relax_sum[DW] ? INF : relax_sum[DW-1:0];
  assign wb_we     = wb_busy_r && (rd_b_data != INF) && (relax_sat < rd_a_data);

  // Write port selection; the sources are active in separate cycles.
  always_comb begin
    priority if (cmd.sweep_step) begin
      wr_en   = 1'b1;
      wr_addr = {i_r, j_r};
      wr_data = (i_r == j_r) ? '0 : INF;
    end else if (cmd.edge_wr) begin
      wr_en   = (cap_r != DW'(1));
      wr_addr = {s_q, d_q};
      wr_data = DW'(1);
    end else if (cmd.full_step) begin
      wr_en   = full_allow;
      wr_addr = {i_r, j_r};
      wr_data = DW'(1);
    end else begin
      wr_en   = wb_we;
      wr_addr = {wb_i_r, wb_j_r};
      wr_data = relax_sat;
    end
  end

  // Read port A serves row heads, point reads and the target row.
  always_comb begin
    priority if (cmd.col_step) begin
      rd_a_addr = {i_r, j_r};
    end else if (cmd.edge_rd) begin
      rd_a_addr = {s_q, d_q};
    end else begin
      rd_a_addr = {i_r, k_r};
    end
  end

  assign rd_b_addr = {k_r, j_r};

  // Core index of source and destination, one quotient bit per step.
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CFG_W-1:0]     rem_s_r, rem_d_r;
  logic [QF_W-1:0]      dvd_s_r, dvd_d_r;
  logic [QF_W-1:0]      quo_s_r, quo_d_r;
  logic [CFG_W:0]       step_s, step_d;
  logic                 cd;

  function automatic logic [CFG_W:0] div_bit(input logic [CFG_W-1:0] rem,
                                             input logic in_bit,
                                             input logic [CFG_W-1:0] divisor);
    logic [CFG_W:0] trial;
    trial = {rem, in_bit};
    if (trial >= {1'b0, divisor}) begin
      div_bit = {CFG_W'(trial - {1'b0, divisor}), 1'b1};
    end else begin
      div_bit = {trial[CFG_W-1:0], 1'b0};
    end
  endfunction

  assign step_s = div_bit(rem_s_r, dvd_s_r[QF_W-1], qpc_r);
  assign step_d = div_bit(rem_d_r, dvd_d_r[QF_W-1], qpc_r);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_cnt_r <= '0;
      rem_s_r   <= '0;
      rem_d_r   <= '0;
      dvd_s_r   <= src_r;
      dvd_d_r   <= dst_r;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      rem_s_r   <= step_s[CFG_W:1];
      rem_d_r   <= step_d[CFG_W:1];
      dvd_s_r   <= {dvd_s_r[QF_W-2:0], 1'b0};
      dvd_d_r   <= {dvd_d_r[QF_W-2:0], 1'b0};
      quo_s_r   <= {quo_s_r[QF_W-2:0], step_s[0]};
      quo_d_r   <= {quo_d_r[QF_W-2:0], step_d[0]};
    end
  end

  assign cd = (qpc_r != '0) && (quo_s_r != quo_d_r);

  // Result beat.
  logic          query_ok;
  status_t       res_status;
  logic [DW:0]   plus2;
  logic [DW-1:0] mh;

  assign query_ok = (opcode_r == OP_QUERY) && !oor;
  assign plus2    = {1'b0, cap_r} + (DW + 1)'(2);
  assign mh       = (cap_r == DW'(cd)) ? (plus2 > {1'b0, INF} ? INF : plus2[DW-1:0]) : cap_r;

  always_comb begin
    priority if (((opcode_r == OP_EDGE) || (opcode_r == OP_QUERY)) && oor) begin
      res_status = STS_RANGE;
    end else if ((opcode_r == OP_EDGE) && dup_r) begin
      res_status = STS_DUP;
    end else begin
      res_status = STS_OK;
    end
  end

  logic          out_valid_r;
  status_t       out_status_r;
  logic [DW-1:0] out_hop_r, out_mh_r;
  logic          out_cd_r, out_reach_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      out_status_r <= res_status;
      out_hop_r    <= query_ok ? cap_r : '0;
      out_cd_r     <= query_ok && cd;
      out_mh_r     <= query_ok ? mh : '0;
      out_reach_r  <= query_ok && (cap_r != INF);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_hop_distance  = out_hop_r;
  assign out_core_distance = out_cd_r;
  assign out_min_hops      = out_mh_r;
  assign out_reachable     = out_reach_r;

  // Status to the controller.
  always_comb begin
    stat              = '0;
    stat.opcode       = opcode_r;
    stat.out_of_range = oor;
    stat.self_loop    = (src_r == dst_r);
    stat.full_mode    = full_conn_r;
    stat.n_zero       = (n_act == '0);
    stat.sweep_last   = (i_r == Q_TOP) && sweep_row_end;
    stat.div_done     = (div_cnt_r == DIV_CNT_W'(QF_W - 1));
    stat.full_last    = i_last && j_last;
    stat.a_inf        = (rd_a_data == INF);
    stat.j_last       = j_last;
    stat.i_last       = i_last;
    stat.k_last       = k_last;
    stat.out_busy     = out_valid_r && !out_ready;
    stat.wb_busy      = wb_busy_r;
  end

endmodule

// ----- hdl/qubit_grid_distance_table.sv -----
// All-pairs hop-distance table for a qubit connectivity graph, held in a
// MAX_QUBITS x MAX_QUBITS dual-read memory of DIST_WIDTH-bit entries (all ones
// means unreachable). Each input beat is one command and yields exactly one
// result beat. A query uses a six-step core-index divider; clear writes one
// entry per cycle through the single table write port; compute runs the
// full-connectivity pass when enabled, then the Floyd-Warshall relaxation
// over the n active qubits (one column update per cycle, rows whose pivot
// entry is unreachable are skipped). After reset the table is cleared by a
// pass over all MAX_QUBITS^2 entries during which no input beat is taken;
// configuration writes are accepted at any time and should be made only while
// idle.
module qubit_grid_distance_table import qgdt_pkg::*; #(
  parameter int MAX_QUBITS = 64,
  parameter int DIST_WIDTH = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_opcode,
  input  logic [QF_W-1:0]       in_src_qubit,
  input  logic [QF_W-1:0]       in_dst_qubit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [DIST_WIDTH-1:0] out_hop_distance,
  output logic                  out_core_distance,
  output logic [DIST_WIDTH-1:0] out_min_hops,
  output logic                  out_reachable
);

  cmd_t  cmd;
  stat_t stat;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  qgdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  qgdt_dp #(
    .MAX_QUBITS (MAX_QUBITS),
    .DIST_WIDTH (DIST_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_opcode         (in_opcode),
    .in_src_qubit      (in_src_qubit),
    .in_dst_qubit      (in_dst_qubit),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_hop_distance  (out_hop_distance),
    .out_core_distance (out_core_distance),
    .out_min_hops      (out_min_hops),
    .out_reachable     (out_reachable),
    .cmd               (cmd),
    .stat              (stat)
  );

  // An accepted beat keeps the block busy for at least the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accepted beat");

  // Loading a result always presents it on the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp_load |=> out_valid)
    else $error("result load did not raise out_valid");

  // Table access commands never overlap.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.sweep_step, cmd.edge_wr, cmd.full_step, cmd.col_step, cmd.edge_rd}))
    else $error("overlapping table access commands");

  // No relaxation write-back is outstanding when a new beat may enter.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.wb_busy)
    else $error("write-back pending while idle");

endmodule
